FILE: rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants for the box frustum cull block
// Plane register layout, plane count, hint encoding and verdict codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afc_pkg;

    localparam int NUM_PLANES      = 6;
    localparam int PLANE_REG_W     = 64;
    localparam int NORM_W          = 16;
    localparam int NORM_FRAC       = 14;
    localparam int OFFSET_W        = 16;
    localparam int MASK_W          = 6;
    localparam int HINT_W          = 3;
    localparam int PADDR_W         = 6;
    localparam int REG_IDX_LSB     = 3;
    localparam int COORD_WIDTH_DEF = 16;

    localparam logic [HINT_W-1:0] NO_HINT = 3'd6;

    typedef enum logic [1:0] {
        V_INSIDE    = 2'd0,
        V_INTERSECT = 2'd1,
        V_OUTSIDE   = 2'd2
    } t_verdict;

    typedef logic signed [NORM_W-1:0]   t_norm;
    typedef logic signed [OFFSET_W-1:0] t_offset;
    typedef logic [PLANE_REG_W-1:0]     t_plane_reg;

endpackage

FILE: rtl/aabb_frustum_cull_top.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_top: box versus six-plane frustum classifier
// Tests one axis-aligned box per cycle against six outward-facing planes and
// reports inside, intersecting or outside with an updated inside mask and hint.
//
// Usage: the six planes are written over the APB-style port, plane i at byte
// address 8*i, 64 bits each (normals Q2.14 in bits 63..16, offset Q12.4 in
// 15..0). Writes complete in the access cycle since pready is tied high.
// The user must write planes only while no box is in flight; the block does
// not enforce this. A box beat is taken at every clock edge where start is
// high; busy never rises, so a new box may enter every cycle. Each box gives
// exactly one result beat, marked by o_valid for one cycle. Throughput is
// one box per clock. The pipeline is one input register, then the corner
// products, the plane sums with their sign tests, and the mask and hint
// resolution, each a register stage of its own. The receiver cannot stall,
// so no backpressure is needed. Reset clears the planes to zero and drops
// every box still in the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_frustum_cull_top
    import afc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Box channel
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_min_z,
    input  logic signed [COORD_WIDTH-1:0] i_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_max_z,
    input  logic [MASK_W-1:0]             i_mask_in,
    input  logic [HINT_W-1:0]             i_hint_in,
    // Result channel
    output logic                          o_valid,
    output logic [1:0]                    o_verdict,
    output logic [MASK_W-1:0]             o_mask_out,
    output logic [HINT_W-1:0]             o_hint_out,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PLANE_REG_W-1:0]        pwdata,
    output logic [PLANE_REG_W-1:0]        prdata,
    output logic                          pready
);

    // A product of a Q2.14 normal and a coordinate, and the offset scaled by
    // 2^14 to the same binary point. Two guard bits cover the four-term sum.
    localparam int PROD_W  = NORM_W + COORD_WIDTH;
    localparam int OFFS_W  = OFFSET_W + NORM_FRAC;
    localparam int SUM_W   = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 2;
    localparam int REG_IDX_W = PADDR_W - REG_IDX_LSB;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [SUM_W-1:0]       t_sum;

    // ------------------------------------------------------------------
    // Plane registers and configuration port
    // ------------------------------------------------------------------
    t_plane_reg r_plane [NUM_PLANES];

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:REG_IDX_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_plane[p] <= '0;
            end
        end else if (cfg_wr) begin
            // Indexes past the last plane match no entry and are dropped.
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (cfg_idx == REG_IDX_W'(p)) begin
                    r_plane[p] <= pwdata;
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (cfg_idx == REG_IDX_W'(p)) begin
                prdata = r_plane[p];
            end
        end
    end

    // Every cycle can take a box.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    t_coord            r_s1_min [3];
    t_coord            r_s1_max [3];
    logic [MASK_W-1:0] r_s1_mask;
    logic [HINT_W-1:0] r_s1_hint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_min[0] <= i_min_x;
        r_s1_min[1] <= i_min_y;
        r_s1_min[2] <= i_min_z;
        r_s1_max[0] <= i_max_x;
        r_s1_max[1] <= i_max_y;
        r_s1_max[2] <= i_max_z;
        r_s1_mask   <= i_mask_in;
        r_s1_hint   <= i_hint_in;
    end

    // ------------------------------------------------------------------
    // Stage 2: near and far corner products, one multiplier per term
    // ------------------------------------------------------------------
    t_prod             n_prod_near [NUM_PLANES][3];
    t_prod             n_prod_far  [NUM_PLANES][3];
    t_prod             r_prod_near [NUM_PLANES][3];
    t_prod             r_prod_far  [NUM_PLANES][3];
    logic              r_s2_valid;
    logic [MASK_W-1:0] r_s2_mask;
    logic [HINT_W-1:0] r_s2_hint;

    always_comb begin
        t_norm  nrm;
        t_coord near_c;
        t_coord far_c;
        logic   pos;
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < 3; a++) begin
                nrm = t_norm'(r_plane[p][PLANE_REG_W-1-NORM_W*a -: NORM_W]);
                // A zero component is not positive: near takes the max.
                pos    = !nrm[NORM_W-1] && (|nrm);
                near_c = pos ? r_s1_min[a] : r_s1_max[a];
                far_c  = pos ? r_s1_max[a] : r_s1_min[a];
                n_prod_near[p][a] = PROD_W'(nrm) * PROD_W'(near_c);
                n_prod_far[p][a]  = PROD_W'(nrm) * PROD_W'(far_c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_near <= n_prod_near;
        r_prod_far  <= n_prod_far;
        r_s2_mask   <= r_s1_mask;
        r_s2_hint   <= r_s1_hint;
    end

    // ------------------------------------------------------------------
    // Stage 3: plane sums and their sign tests
    // ------------------------------------------------------------------
    logic [NUM_PLANES-1:0] n_s3_out;
    logic [NUM_PLANES-1:0] n_s3_far;
    logic [NUM_PLANES-1:0] r_s3_out;
    logic [NUM_PLANES-1:0] r_s3_far;
    logic                  r_s3_valid;
    logic [MASK_W-1:0]     r_s3_mask;
    logic [HINT_W-1:0]     r_s3_hint;

    always_comb begin
        t_sum    offs;
        t_sum    near_sum;
        t_sum    far_sum;
        t_offset d;
        for (int p = 0; p < NUM_PLANES; p++) begin
            d        = t_offset'(r_plane[p][OFFSET_W-1:0]);
            offs     = SUM_W'(d) <<< NORM_FRAC;
            near_sum = offs + SUM_W'(r_prod_near[p][0]) + SUM_W'(r_prod_near[p][1])
                       + SUM_W'(r_prod_near[p][2]);
            far_sum  = offs + SUM_W'(r_prod_far[p][0]) + SUM_W'(r_prod_far[p][1])
                       + SUM_W'(r_prod_far[p][2]);
            n_s3_out[p] = !near_sum[SUM_W-1] && (|near_sum);
            n_s3_far[p] = !far_sum[SUM_W-1] && (|far_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_out  <= n_s3_out;
        r_s3_far  <= n_s3_far;
        r_s3_mask <= r_s2_mask;
        r_s3_hint <= r_s2_hint;
    end

    // ------------------------------------------------------------------
    // Stage 4: mask and hint resolution
    // ------------------------------------------------------------------
    // The hinted plane goes first. If it is unmasked and rejects, mask and hint
    // pass through. Otherwise the remaining planes are scanned in index order and
    // the first rejecting one wins, reporting the mask gathered before it.
    t_verdict          n_out_verdict;
    logic [MASK_W-1:0] n_out_mask;
    logic [HINT_W-1:0] n_out_hint;
    t_verdict          r_out_verdict;
    logic [MASK_W-1:0] r_out_mask;
    logic [HINT_W-1:0] r_out_hint;
    logic              r_out_valid;

    always_comb begin
        logic [NUM_PLANES-1:0] hint_oh;
        logic [NUM_PLANES-1:0] mask1;
        logic [NUM_PLANES-1:0] acc;
        logic [NUM_PLANES-1:0] rej_mask;
        logic [HINT_W-1:0]     rej_idx;
        logic                  hint_act;
        logic                  any_cross;
        logic                  found;
        for (int p = 0; p < NUM_PLANES; p++) begin
            hint_oh[p] = (r_s3_hint == HINT_W'(p));
        end
        hint_act  = |(hint_oh & ~r_s3_mask);
        mask1     = r_s3_mask | (hint_oh & ~r_s3_far);
        any_cross = |(hint_oh & ~r_s3_mask & r_s3_far);
        acc       = mask1;
        rej_mask  = mask1;
        rej_idx   = NO_HINT;
        found     = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (!found && !mask1[p] && !hint_oh[p]) begin
                if (r_s3_out[p]) begin
                    found    = 1'b1;
                    rej_mask = acc;
                    rej_idx  = HINT_W'(p);
                end else if (r_s3_far[p]) begin
                    any_cross = 1'b1;
                end else begin
                    acc[p] = 1'b1;
                end
            end
        end
        priority if (hint_act && (|(hint_oh & r_s3_out))) begin
            n_out_verdict = V_OUTSIDE;
            n_out_mask    = r_s3_mask;
            n_out_hint    = r_s3_hint;
        end else if (found) begin
            n_out_verdict = V_OUTSIDE;
            n_out_mask    = rej_mask;
            n_out_hint    = rej_idx;
        end else begin
            n_out_verdict = any_cross ? V_INTERSECT : V_INSIDE;
            n_out_mask    = acc;
            n_out_hint    = NO_HINT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_verdict <= n_out_verdict;
        r_out_mask    <= n_out_mask;
        r_out_hint    <= n_out_hint;
    end

    assign o_valid    = r_out_valid;
    assign o_verdict  = r_out_verdict;
    assign o_mask_out = r_out_mask;
    assign o_hint_out = r_out_hint;

`ifndef SYNTHESIS
    // Every box taken gives its result beat.
    a_box_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("box beat produced no result beat");

    // A plane is named in the hint exactly when the box was rejected.
    a_hint_matches_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_verdict == V_OUTSIDE) == (o_hint_out != NO_HINT)))
        else $error("hint out disagrees with verdict");

    // An inside box must have marked every plane as fully inside.
    a_inside_full_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_verdict == V_INSIDE)) |-> (o_mask_out == '1))
        else $error("inside verdict with incomplete mask");
`endif

endmodule
